// ===== rtl/assert_macros.svh =====
// Assertion macros used by the mask surface compositor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define MSC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define MSC_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/msc_pkg.sv =====
// Shared types, constants and arithmetic helpers of the mask surface compositor.
package msc_pkg;

	// Field widths
	localparam int OP_W     = 3;
	localparam int COORD_W  = 16;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int REG_W    = 9;
	localparam int CFG_IDX_W = 1;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 16;

	// Default surface limits
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	// Byte arithmetic constants
	localparam logic [BYTE_W-1:0] FULL_BYTE  = 8'd255;
	localparam logic [BYTE_W-1:0] ROUND_HALF = 8'd127;

	// Operation codes
	localparam logic [OP_W-1:0] OP_CLEAR     = 3'd0;
	localparam logic [OP_W-1:0] OP_FILL      = 3'd1;
	localparam logic [OP_W-1:0] OP_SET       = 3'd2;
	localparam logic [OP_W-1:0] OP_UNION     = 3'd3;
	localparam logic [OP_W-1:0] OP_INTERSECT = 3'd4;
	localparam logic [OP_W-1:0] OP_SUBTRACT  = 3'd5;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_WRITTEN = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CLIPPED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MASK_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_HEIGHT = 1'd1;

	// Request handed to the blend unit
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] old_value;
		logic [BYTE_W-1:0] src_value;
	} alu_req_t;

	// (p + 127) / 255 without a divider; exact for p up to 255*255
	function automatic logic [BYTE_W-1:0] div255_round(input logic [15:0] p);
		logic [16:0] t;
		logic [16:0] u;
		t = {1'b0, p} + {9'd0, ROUND_HALF};
		u = t + {8'd0, t[16:8]} + 17'd1;
		return u[15:8];
	endfunction

endpackage

// ===== rtl/msc_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module msc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/msc_alu.sv =====
// Blend unit: operand select and byte product, registered, then rounding and op select.
module msc_alu (
	input  logic                          clk,
	input  logic                          load,
	input  msc_pkg::alu_req_t             req,
	output logic [msc_pkg::BYTE_W-1:0]    result
);

	logic [msc_pkg::BYTE_W-1:0] opa;
	logic [msc_pkg::BYTE_W-1:0] opb;
	logic [15:0]                prod_s2;
	logic [msc_pkg::OP_W-1:0]   op_s2;
	logic [msc_pkg::BYTE_W-1:0] src_s2;
	logic [msc_pkg::BYTE_W-1:0] quot;

	// Operand select: union works on complements, subtract on complemented source
	always_comb begin
		unique case (req.op)
			msc_pkg::OP_UNION: begin
				opa = msc_pkg::FULL_BYTE - req.old_value;
				opb = msc_pkg::FULL_BYTE - req.src_value;
			end
			msc_pkg::OP_INTERSECT: begin
				opa = req.old_value;
				opb = req.src_value;
			end
			default: begin
				opa = req.old_value;
				opb = msc_pkg::FULL_BYTE - req.src_value;
			end
		endcase
	end

	// Product register
	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2 <= {8'd0, opa} * {8'd0, opb};
			op_s2   <= req.op;
			src_s2  <= req.src_value;
		end
	end

	assign quot = msc_pkg::div255_round(prod_s2);

	// Final byte per operation
	always_comb begin
		unique case (op_s2)
			msc_pkg::OP_CLEAR:     result = '0;
			msc_pkg::OP_FILL:      result = msc_pkg::FULL_BYTE;
			msc_pkg::OP_SET:       result = src_s2;
			msc_pkg::OP_UNION:     result = msc_pkg::FULL_BYTE - quot;
			default:               result = quot;
		endcase
	end

endmodule

// ===== rtl/mask_surface_compositor_top.sv =====
// Mask surface compositor: 8-bit coverage mask with per-pixel read-modify-write.
//
// Input stream (s_axis): one pixel request per transfer with an operation,
// signed x/y and a source byte. Output stream (m_axis): one result per request
// with the resulting byte and a status (written, clipped, illegal op).
// Config port: cfg_wr_en/cfg_index/cfg_wdata write mask_width (0) and
// mask_height (1); write only while no request is in flight.
//
// After reset the mask RAM is swept to 255, one byte a cycle, over all
// MAX_WIDTH*MAX_HEIGHT addresses (65536 by default); s_axis_tready stays low.
// An accepted request passes the read stage, the write-back stage and the
// output register to m_axis; the single mask RAM is read, blended and
// written back for one pixel before the next request is taken.
// When m_axis_tready is low, the result waits in the output register, the
// next finished pixel waits in the write-back stage and s_axis_tready stays
// low until the output drains.
module mask_surface_compositor_top #(
	parameter int MAX_WIDTH  = msc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = msc_pkg::MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write port
	input  logic                              cfg_wr_en,
	input  logic [msc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [msc_pkg::REG_W-1:0]         cfg_wdata,
	// pixel requests
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata: mask_op[2:0], pixel_x[18:3], pixel_y[34:19], source_value[42:35], zero pad
	input  logic [msc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// results
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata: result_value[7:0], op_status[9:8], zero pad
	output logic [msc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	`include "assert_macros.svh"

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Config registers
	logic [msc_pkg::REG_W-1:0] mask_width_q;
	logic [msc_pkg::REG_W-1:0] mask_height_q;

	// Clearing sweep
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	// Request fields
	logic [msc_pkg::OP_W-1:0]    op_in;
	logic [msc_pkg::COORD_W-1:0] x_in;
	logic [msc_pkg::COORD_W-1:0] y_in;
	logic [msc_pkg::BYTE_W-1:0]  src_in;

	logic [msc_pkg::REG_W-1:0]    w_eff;
	logic [msc_pkg::REG_W-1:0]    h_eff;
	logic                         inside_in;
	logic [17:0]                  row_base;
	logic [18:0]                  lin_idx;
	logic [msc_pkg::STATUS_W-1:0] status_in;
	logic                         accept;

	// Read stage
	logic                         valid_s1;
	logic [msc_pkg::OP_W-1:0]     op_s1;
	logic [msc_pkg::BYTE_W-1:0]   src_s1;
	logic                         inside_s1;
	logic [msc_pkg::STATUS_W-1:0] status_s1;
	logic [AW-1:0]                idx_s1;
	logic [msc_pkg::BYTE_W-1:0]   rd_data;
	logic [msc_pkg::BYTE_W-1:0]   old_s1;
	msc_pkg::alu_req_t            alu_req;

	// Write-back stage
	logic                         valid_s2;
	logic [msc_pkg::STATUS_W-1:0] status_s2;
	logic [AW-1:0]                idx_s2;
	logic [msc_pkg::BYTE_W-1:0]   old_s2;
	logic [msc_pkg::BYTE_W-1:0]   blend_s2;
	logic [msc_pkg::BYTE_W-1:0]   res_s2;
	logic                         out_free;
	logic                         retire;
	logic                         px_we;

	// RAM write port
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [msc_pkg::BYTE_W-1:0]   ram_wdata;

	// Output register
	logic                         m_valid_q;
	logic [msc_pkg::BYTE_W-1:0]   m_result_q;
	logic [msc_pkg::STATUS_W-1:0] m_status_q;

	// Unpack request
	assign op_in  = s_axis_tdata[2:0];
	assign x_in   = s_axis_tdata[18:3];
	assign y_in   = s_axis_tdata[34:19];
	assign src_in = s_axis_tdata[42:35];

	// Saturate size registers to the surface limits
	assign w_eff = (mask_width_q > MAX_WIDTH) ? msc_pkg::REG_W'(MAX_WIDTH) : mask_width_q;
	assign h_eff = (mask_height_q > MAX_HEIGHT) ? msc_pkg::REG_W'(MAX_HEIGHT) : mask_height_q;

	// Clip test and linear address
	assign inside_in = !x_in[15] && !y_in[15] &&
		(x_in < {7'd0, w_eff}) && (y_in < {7'd0, h_eff});
	assign row_base = {9'd0, y_in[8:0]} * {9'd0, w_eff};
	assign lin_idx  = {1'b0, row_base} + {10'd0, x_in[8:0]};

	always_comb begin
		priority if (op_in > msc_pkg::OP_SUBTRACT) begin
			status_in = msc_pkg::ST_ILLEGAL;
		end else if (!inside_in) begin
			status_in = msc_pkg::ST_CLIPPED;
		end else begin
			status_in = msc_pkg::ST_WRITTEN;
		end
	end

	// One pixel in flight at a time
	assign s_axis_tready = !clearing_q && !valid_s1 && !valid_s2;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_width_q  <= '0;
			mask_height_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				msc_pkg::REG_MASK_WIDTH:  mask_width_q  <= cfg_wdata;
				msc_pkg::REG_MASK_HEIGHT: mask_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (retire) begin
				valid_s2 <= 1'b0;
			end
			if (retire) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Read stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op_in;
			src_s1    <= src_in;
			inside_s1 <= inside_in;
			status_s1 <= status_in;
			idx_s1    <= AW'(lin_idx);
		end
	end

	msc_ram #(
		.WIDTH (msc_pkg::BYTE_W),
		.DEPTH (DEPTH)
	) u_mask_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (AW'(lin_idx)),
		.rdata (rd_data)
	);

	// Old byte counts only for a pixel inside the surface
	assign old_s1 = inside_s1 ? rd_data : '0;

	assign alu_req.op        = op_s1;
	assign alu_req.old_value = old_s1;
	assign alu_req.src_value = src_s1;

	msc_alu u_alu (
		.clk    (clk),
		.load   (valid_s1),
		.req    (alu_req),
		.result (blend_s2)
	);

	// Write-back stage payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_s2 <= status_s1;
			idx_s2    <= idx_s1;
			old_s2    <= old_s1;
		end
	end

	always_comb begin
		unique case (status_s2)
			msc_pkg::ST_WRITTEN: res_s2 = blend_s2;
			msc_pkg::ST_ILLEGAL: res_s2 = old_s2;
			default:             res_s2 = '0;
		endcase
	end

	assign out_free = !m_valid_q || m_axis_tready;
	assign retire   = valid_s2 && out_free;
	assign px_we    = retire && (status_s2 == msc_pkg::ST_WRITTEN);

	// RAM write: clearing sweep or pixel write-back
	assign ram_we    = clearing_q || px_we;
	assign ram_waddr = clearing_q ? clr_addr_q : idx_s2;
	assign ram_wdata = clearing_q ? msc_pkg::FULL_BYTE : res_s2;

	// Output register payload
	always_ff @(posedge clk) begin
		if (retire) begin
			m_result_q <= res_s2;
			m_status_q <= status_s2;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, m_status_q, m_result_q};

	// Checks
	`MSC_NEVER(a_no_px_write_in_clear, clk, arst_n, clearing_q && px_we, "pixel write during clearing sweep")
	`MSC_ASSERT(a_one_in_flight, clk, arst_n, $onehot0({valid_s1, valid_s2}), "more than one pixel in flight")
	`MSC_ASSERT(a_s1_to_s2, clk, arst_n, valid_s1 |=> valid_s2, "read stage did not advance to write-back")
	`MSC_ASSERT(a_clip_zero, clk, arst_n, (m_valid_q && m_status_q == msc_pkg::ST_CLIPPED) |-> (m_result_q == '0), "clipped result not zero")

endmodule
